[rtl/core/sie_pkg.sv]
// Shared types, character codes and decode helpers for the infix evaluator core.
package sie_pkg;

    // Pending operator codes
    typedef enum logic [1:0] {
        OP_PLUS   = 2'd0,
        OP_MINUS  = 2'd1,
        OP_TIMES  = 2'd2,
        OP_DIVIDE = 2'd3
    } t_op;

    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_TIMES  = 8'h2A;
    localparam logic [7:0] CH_DIVIDE = 8'h2F;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;

    localparam int OUT_WIDTH = 32;

    function automatic logic is_digit(input logic [7:0] ch);
        return (ch >= CH_ZERO) && (ch <= CH_NINE);
    endfunction

    function automatic logic is_oper(input logic [7:0] ch);
        return (ch == CH_PLUS) || (ch == CH_MINUS) || (ch == CH_TIMES) || (ch == CH_DIVIDE);
    endfunction

    function automatic t_op op_of(input logic [7:0] ch);
        t_op op;
        priority if (ch == CH_PLUS) begin
            op = OP_PLUS;
        end else if (ch == CH_MINUS) begin
            op = OP_MINUS;
        end else if (ch == CH_TIMES) begin
            op = OP_TIMES;
        end else begin
            op = OP_DIVIDE;
        end
        return op;
    endfunction

endpackage

[rtl/core/streaming_infix_expression_evaluator_core.sv]
// Streaming infix expression evaluator: one shared adder under a small sequencer.
// Each accepted item walks the sequencer steps for its kind: an ignored character returns
// to idle; a digit multiplies the running value by ten and adds the digit; an operator or
// the end-of-expression item folds the pending operator into the total; the end-of-expression
// item then adds the total and waits until the previous result has been taken by the
// receiver. Multiply and divide run a radix-2 loop on the one adder; one item is in
// flight at a time.
// Reset (synchronous, active low) clears the accumulators, flags and sequencer.
module streaming_infix_expression_evaluator_core
    import sie_pkg::*;
#(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // input channel
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [7:0]           i_char_code,
    input  logic                 i_end_of_expr,
    // result channel
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic signed [31:0]   o_value,
    output logic                 o_div_by_zero,
    output logic                 o_overflowed
);

    localparam int W  = VALUE_WIDTH;
    // Adder width: wide enough to hold ten times any W-bit signed value exactly
    localparam int AW = VALUE_WIDTH + 4;
    localparam int CW = $clog2(VALUE_WIDTH);
    localparam logic [W-1:0] MIN_VAL = {1'b1, {(W-1){1'b0}}};

    typedef enum logic [3:0] {
        S_IDLE,
        S_DMUL,   // digit_accum * 10
        S_DADD,   // + digit
        S_FOLD,   // dispatch on pending operator, add for plus/minus
        S_NEG,    // negate digit_accum (minus)
        S_MAGA,   // magnitude of left operand
        S_MAGB,   // magnitude of right operand
        S_ITER,   // one bit of shift-add multiply or restoring divide
        S_SIGN,   // apply sign, check product range
        S_OPSET,  // latch new operator
        S_TOTAL,  // running_total += digit_accum
        S_EMIT    // load result register, clear state
    } t_state;

    t_state         r_state, n_state;

    // model state
    logic [W-1:0]   r_accum;
    logic [W-1:0]   r_term;
    logic [W-1:0]   r_total;
    t_op            r_op;
    logic           r_zdiv;
    logic           r_ovf;

    // item and datapath working registers
    logic [7:0]     r_char;
    logic           r_last;
    logic           r_phase;   // 0: fold for an operator, 1: fold for end of expression
    logic           r_neg;
    logic [W-1:0]   r_hi;
    logic [W-1:0]   r_lo;
    logic [W-1:0]   r_opb;
    logic [CW-1:0]  r_cnt;

    // result register
    logic           r_out_valid;
    logic [31:0]    r_value;
    logic           r_out_zdiv;
    logic           r_out_ovf;

    // shared adder
    logic [AW-1:0]  alu_a, alu_b, alu_sum;
    logic           alu_cin;
    logic           alu_ovf;

    logic [AW-1:0]  accum_sx, term_sx, total_sx;
    logic [W:0]     trial;
    logic           div_ge;
    logic           mul_ovf;
    logic           emit_go;
    logic           in_fire;
    t_state         after_char, after_fold;

    assign accum_sx = {{4{r_accum[W-1]}}, r_accum};
    assign term_sx  = {{4{r_term[W-1]}}, r_term};
    assign total_sx = {{4{r_total[W-1]}}, r_total};

    // Restoring divide: shift next dividend bit into the partial remainder
    assign trial  = {r_hi, r_lo[W-1]};
    assign div_ge = ~alu_sum[AW-1];

    // Product magnitude against the signed range for the result sign
    assign mul_ovf = r_neg ? ((|r_hi) | (r_lo[W-1] & (|r_lo[W-2:0])))
                           : ((|r_hi) | r_lo[W-1]);

    // Select adder operands by sequencer step
    always_comb begin
        alu_a   = '0;
        alu_b   = '0;
        alu_cin = 1'b0;
        unique case (r_state)
            S_DMUL: begin
                alu_a = accum_sx << 3;
                alu_b = accum_sx << 1;
            end
            S_DADD: begin
                alu_a = accum_sx;
                alu_b = {{W{1'b0}}, r_char[3:0]};   // ASCII digit low nibble is its value
            end
            S_FOLD, S_TOTAL: begin
                alu_a = total_sx;
                alu_b = (r_state == S_FOLD) ? term_sx : accum_sx;
            end
            S_NEG: begin
                alu_b   = ~accum_sx;
                alu_cin = 1'b1;
            end
            S_MAGA: begin
                alu_b   = term_sx ^ {AW{r_term[W-1]}};
                alu_cin = r_term[W-1];
            end
            S_MAGB: begin
                alu_b   = accum_sx ^ {AW{r_accum[W-1]}};
                alu_cin = r_accum[W-1];
            end
            S_ITER: begin
                if (r_op == OP_DIVIDE) begin
                    alu_a   = {3'b0, trial};
                    alu_b   = ~{4'b0, r_opb};
                    alu_cin = 1'b1;
                end else begin
                    alu_a = {4'b0, r_hi};
                    alu_b = r_lo[0] ? {4'b0, r_opb} : '0;
                end
            end
            S_SIGN: begin
                alu_b   = {4'b0, r_lo} ^ {AW{r_neg}};
                alu_cin = r_neg;
            end
            S_IDLE, S_OPSET, S_EMIT: begin
                alu_a = '0;
            end
        endcase
    end

    assign alu_sum = alu_a + alu_b + {{(AW-1){1'b0}}, alu_cin};
    // Signed W-bit overflow: the exact sum does not sign-extend from bit W-1
    assign alu_ovf = ~((&alu_sum[AW-1:W-1]) | ~(|alu_sum[AW-1:W-1]));

    assign in_fire    = i_in_valid && o_in_ready;
    assign emit_go    = !r_out_valid || i_out_ready;
    assign after_char = r_last ? S_FOLD : S_IDLE;
    assign after_fold = r_phase ? S_TOTAL : S_OPSET;

    // Next step of the sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    priority if (is_digit(i_char_code)) begin
                        n_state = S_DMUL;
                    end else if (is_oper(i_char_code) || i_end_of_expr) begin
                        n_state = S_FOLD;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_DMUL:  n_state = S_DADD;
            S_DADD:  n_state = after_char;
            S_FOLD: begin
                unique case (r_op)
                    OP_PLUS:  n_state = after_fold;
                    OP_MINUS: n_state = S_NEG;
                    OP_TIMES: n_state = S_MAGA;
                    OP_DIVIDE: begin
                        if (r_accum == '0 || (r_term == MIN_VAL && (&r_accum))) begin
                            n_state = after_fold;
                        end else begin
                            n_state = S_MAGA;
                        end
                    end
                endcase
            end
            S_NEG:   n_state = after_fold;
            S_MAGA:  n_state = S_MAGB;
            S_MAGB:  n_state = S_ITER;
            S_ITER:  n_state = (r_cnt == '0) ? S_SIGN : S_ITER;
            S_SIGN:  n_state = after_fold;
            S_OPSET: n_state = after_char;
            S_TOTAL: n_state = S_EMIT;
            S_EMIT:  n_state = emit_go ? S_IDLE : S_EMIT;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_accum     <= '0;
            r_term      <= '0;
            r_total     <= '0;
            r_op        <= OP_PLUS;
            r_zdiv      <= 1'b0;
            r_ovf       <= 1'b0;
            r_phase     <= 1'b0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            // Drop the result once taken, unless a new one loads in the same cycle
            if (r_out_valid && i_out_ready && r_state != S_EMIT) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_fire) begin
                        r_char  <= i_char_code;
                        r_last  <= i_end_of_expr;
                        r_phase <= !is_oper(i_char_code);
                    end
                end
                S_DMUL, S_DADD: begin
                    r_accum <= alu_sum[W-1:0];
                    r_ovf   <= r_ovf | alu_ovf;
                    r_phase <= 1'b1;
                end
                S_FOLD: begin
                    unique case (r_op)
                        OP_PLUS, OP_MINUS: begin
                            r_total <= alu_sum[W-1:0];
                            r_ovf   <= r_ovf | alu_ovf;
                        end
                        OP_TIMES: begin
                            r_total <= r_total;
                        end
                        OP_DIVIDE: begin
                            // Zero divisor leaves the quotient at zero
                            if (r_accum == '0) begin
                                r_zdiv <= 1'b1;
                            end else if (r_term == MIN_VAL && (&r_accum)) begin
                                r_accum <= MIN_VAL;
                                r_ovf   <= 1'b1;
                            end
                        end
                    endcase
                end
                S_NEG: begin
                    r_accum <= alu_sum[W-1:0];
                    r_ovf   <= r_ovf | alu_ovf;
                end
                S_MAGA: begin
                    r_lo  <= alu_sum[W-1:0];
                    r_hi  <= '0;
                    r_neg <= r_term[W-1] ^ r_accum[W-1];
                end
                S_MAGB: begin
                    r_opb <= alu_sum[W-1:0];
                    r_cnt <= CW'(W - 1);
                end
                S_ITER: begin
                    if (r_op == OP_DIVIDE) begin
                        r_hi <= div_ge ? alu_sum[W-1:0] : trial[W-1:0];
                        r_lo <= {r_lo[W-2:0], div_ge};
                    end else begin
                        r_hi <= alu_sum[W:1];
                        r_lo <= {alu_sum[0], r_lo[W-1:1]};
                    end
                    r_cnt <= r_cnt - 1'b1;
                end
                S_SIGN: begin
                    r_accum <= alu_sum[W-1:0];
                    if (r_op == OP_TIMES) begin
                        r_ovf <= r_ovf | mul_ovf;
                    end
                end
                S_OPSET: begin
                    r_term  <= r_accum;
                    r_accum <= '0;
                    r_op    <= op_of(r_char);
                    r_phase <= 1'b1;
                end
                S_TOTAL: begin
                    r_total <= alu_sum[W-1:0];
                    r_ovf   <= r_ovf | alu_ovf;
                end
                S_EMIT: begin
                    // Hold until the result register is free, then clear the expression
                    if (emit_go) begin
                        r_out_valid <= 1'b1;
                        r_value     <= OUT_WIDTH'($signed(r_total));
                        r_out_zdiv  <= r_zdiv;
                        r_out_ovf   <= r_ovf;
                        r_accum     <= '0;
                        r_term      <= '0;
                        r_total     <= '0;
                        r_op        <= OP_PLUS;
                        r_zdiv      <= 1'b0;
                        r_ovf       <= 1'b0;
                    end
                end
            endcase
        end
    end

    assign o_in_ready    = (r_state == S_IDLE);
    assign o_out_valid   = r_out_valid;
    assign o_value       = r_value;
    assign o_div_by_zero = r_out_zdiv;
    assign o_overflowed  = r_out_ovf;

    // Partial remainder stays below the divisor through the divide loop
    a_rem_below_divisor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ITER && r_op == OP_DIVIDE) |-> (r_hi < r_opb))
        else $error("divide remainder reached divisor");

    // Loop exits to sign fixup after the last bit
    a_loop_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ITER && r_cnt == '0) |=> (r_state == S_SIGN))
        else $error("iteration loop did not terminate");

    // Expression state is cleared once a result is loaded
    a_clear_after_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT && emit_go) |=>
            (r_total == '0 && r_accum == '0 && r_term == '0 && !r_zdiv && !r_ovf
             && r_out_valid))
        else $error("state not cleared after result");

    // Sticky flags drop only when a result is emitted or on reset
    a_sticky_ovf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(r_ovf) |-> ($past(r_state) == S_EMIT || !$past(i_rst_n)))
        else $error("overflow flag dropped mid-expression");

endmodule
